@@ hdl/lbfgs_de_pkg.sv @@
// Shared types and constants for the L-BFGS search-direction engine.
// Request/response payload structs, register indexes and status codes.
// No dependencies.
`default_nettype none

package lbfgs_de_pkg;

   localparam int unsigned MAX_LENGTH_DEF  = 1024;
   localparam int unsigned MAX_HISTORY_DEF = 8;

   localparam int THRESH_W    = 31;
   localparam int LENGTH_W    = 11;
   localparam int DEPTH_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   localparam logic [1:0] KIND_HISTORY  = 2'd0;
   localparam logic [1:0] KIND_GRADIENT = 2'd1;
   localparam logic [1:0] KIND_READ     = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_REJECTED = 2'd1;
   localparam logic [1:0] STATUS_READY    = 2'd2;
   localparam logic [1:0] STATUS_READ     = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH     = 2'd2;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd1;
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd1024;
   localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 4'd8;

   localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

   typedef struct packed {
      logic [1:0]         kind;
      logic [9:0]         index;
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] direction_value;
      logic [3:0]         history_count;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/lbfgs_direction_engine_unit.sv @@
// L-BFGS direction engine: pair ring, two-loop recursion sequencer, divider.
// Loads and reads are taken only in the idle state; a kept pair runs the 64-step
// divider. A gradient close runs the two-loop recursion over n elements and L pairs;
// each element pass reads, multiplies and writes back on single-port vector memories.
// Reset (synchronous): ring empty, direction reads as zero, registers at defaults.
// Depends on lbfgs_de_pkg.
`default_nettype none

module lbfgs_direction_engine_unit
   import lbfgs_de_pkg::*;
#(
   parameter int unsigned MAX_LENGTH  = MAX_LENGTH_DEF,
   parameter int unsigned MAX_HISTORY = MAX_HISTORY_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire req_type           req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output rsp_type                rsp_payload,
   input  wire                    csr_write_en,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_data
);

   localparam int IDX_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int CMP_W  = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
   localparam int SLOT_W = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int CNT_W  = $clog2(MAX_HISTORY + 1);
   localparam int DCMP_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
   localparam int PAIR_DEPTH = 1 << (SLOT_W + IDX_W);
   localparam int VEC_DEPTH  = 1 << IDX_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_HFIN, ST_HCHK, ST_DIV, ST_DIVDONE, ST_PASS_RD,
      ST_PASS_MUL, ST_PASS_WB, ST_POST_T, ST_POST_M, ST_POST_A, ST_GAMMA
   } state_type;

   typedef enum logic [2:0] {
      PASS_DOT_SW, PASS_UPD_SUB, PASS_DOT_SY, PASS_DOT_YY, PASS_SCALE,
      PASS_DOT_YW, PASS_UPD_ADD, PASS_NEG
   } pass_type;

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v[48:31] == '0 || v[48:31] == '1) r = v[31:0];
      else if (v[48]) r = 32'sh8000_0000;
      else r = 32'sh7FFF_FFFF;
      return r;
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [63:0] r;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else r = s[63:0];
      return r;
   endfunction

   // memories
   logic signed [31:0] step_mem [0:PAIR_DEPTH-1];
   logic signed [31:0] chg_mem  [0:PAIR_DEPTH-1];
   logic signed [31:0] work_mem [0:VEC_DEPTH-1];
   logic signed [31:0] dir_mem  [0:VEC_DEPTH-1];

   // registers
   state_type           state_ff;
   pass_type            pass_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic [THRESH_W-1:0] thr_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [SLOT_W-1:0]   head_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    k_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [IDX_W-1:0]    elem_ff;
   logic [LEN_W-1:0]    dir_fill_ff;
   logic                read_hit_ff;
   logic signed [63:0]  pair_acc_ff;
   logic signed [63:0]  pair_prod_ff;
   logic                pair_pend_ff;
   logic                pair_first_ff;
   logic signed [63:0]  dot_acc_ff;
   logic signed [63:0]  prod_ff;
   logic signed [31:0]  dot_t_ff;
   logic signed [31:0]  scal_ff;
   logic signed [47:0]  sy_ff;
   logic signed [47:0]  yy_ff;
   logic signed [31:0]  inv_curv_ff [0:MAX_HISTORY-1];
   logic signed [31:0]  alpha_ff    [0:MAX_HISTORY-1];
   logic signed [31:0]  step_rd_ff;
   logic signed [31:0]  chg_rd_ff;
   logic signed [31:0]  work_rd_ff;
   logic signed [31:0]  dir_rd_ff;
   logic [47:0]         div_rem_ff;
   logic [63:0]         div_dvd_ff;
   logic [47:0]         div_dvs_ff;
   logic [63:0]         div_quo_ff;
   logic [5:0]          div_cnt_ff;
   logic                div_gamma_ff;
   logic                div_neg_ff;

   // decode
   logic [CMP_W-1:0]    len_eff;
   logic [CMP_W-1:0]    len_x;
   logic [CNT_W-1:0]    depth_eff;
   logic [DCMP_W-1:0]   dep_x;
   logic [SLOT_W-1:0]   last_slot;
   logic [SLOT_W-1:0]   newest_slot;
   logic [SLOT_W-1:0]   oldest_slot;
   logic [CNT_W:0]      old_sum;
   logic [SLOT_W-1:0]   head_next;
   logic [CNT_W-1:0]    count_next;
   logic                req_fire;
   logic [CMP_W-1:0]    req_idx_x;
   logic                req_in_range;
   logic                req_last;
   logic [IDX_W-1:0]    req_elem;
   logic                elem_last;
   logic [SLOT_W-1:0]   k_slot;

   always_comb begin
      len_x = CMP_W'(length_ff);
      if (length_ff == '0) len_eff = CMP_W'(1);
      else if (len_x > CMP_W'(MAX_LENGTH)) len_eff = CMP_W'(MAX_LENGTH);
      else len_eff = len_x;
      dep_x = DCMP_W'(depth_ff);
      if (depth_ff == '0) depth_eff = CNT_W'(1);
      else if (dep_x > DCMP_W'(MAX_HISTORY)) depth_eff = CNT_W'(MAX_HISTORY);
      else depth_eff = CNT_W'(dep_x);
   end

   assign last_slot   = SLOT_W'(depth_eff - CNT_W'(1));
   assign newest_slot = (head_ff == '0) ? last_slot : head_ff - SLOT_W'(1);
   assign old_sum     = (CNT_W+1)'(head_ff) + (CNT_W+1)'(depth_eff) - (CNT_W+1)'(count_ff);
   assign oldest_slot = (old_sum >= (CNT_W+1)'(depth_eff))
                        ? SLOT_W'(old_sum - (CNT_W+1)'(depth_eff)) : SLOT_W'(old_sum);
   assign head_next   = (head_ff == last_slot) ? '0 : head_ff + SLOT_W'(1);
   assign count_next  = (count_ff < depth_eff) ? count_ff + CNT_W'(1) : count_ff;
   assign k_slot      = SLOT_W'(k_ff);

   assign req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire     = req_valid && req_ready;
   assign req_idx_x    = CMP_W'(req_payload.index);
   assign req_in_range = req_idx_x < len_eff;
   assign req_last     = req_idx_x == (len_eff - CMP_W'(1));
   assign req_elem     = IDX_W'(req_payload.index);
   assign elem_last    = CMP_W'(elem_ff) == (len_eff - CMP_W'(1));

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // datapath
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] mul_p;
   logic signed [47:0] prod_shift;
   logic signed [47:0] acc_shift;
   logic signed [47:0] ys;
   logic signed [63:0] acc_next;
   logic signed [48:0] wb_sum;
   logic signed [31:0] wb_value;
   logic signed [31:0] post_v;
   logic signed [31:0] coef;
   logic               ys_gt;
   logic               yy_gt;
   logic [47:0]        sy_mag;
   logic [48:0]        div_trial;
   logic               div_ge;
   logic signed [31:0] recip_sat;
   logic signed [31:0] gamma_sat;
   logic               gamma_over;
   logic               is_dot;

   always_comb begin
      mul_a = step_rd_ff;
      mul_b = work_rd_ff;
      if (state_ff == ST_POST_M) begin
         mul_a = inv_curv_ff[slot_ff];
         mul_b = dot_t_ff;
      end else begin
         unique case (pass_ff)
            PASS_DOT_SW:  begin mul_a = step_rd_ff; mul_b = work_rd_ff; end
            PASS_DOT_SY:  begin mul_a = step_rd_ff; mul_b = chg_rd_ff;  end
            PASS_DOT_YY:  begin mul_a = chg_rd_ff;  mul_b = chg_rd_ff;  end
            PASS_DOT_YW:  begin mul_a = chg_rd_ff;  mul_b = work_rd_ff; end
            PASS_UPD_SUB: begin mul_a = scal_ff;    mul_b = chg_rd_ff;  end
            PASS_SCALE:   begin mul_a = scal_ff;    mul_b = work_rd_ff; end
            PASS_UPD_ADD: begin mul_a = scal_ff;    mul_b = step_rd_ff; end
            default:      begin mul_a = step_rd_ff; mul_b = work_rd_ff; end
         endcase
      end
   end

   assign mul_p      = mul_a * mul_b;
   assign prod_shift = prod_ff[63:16];
   assign acc_shift  = dot_acc_ff[63:16];
   assign ys         = pair_acc_ff[63:16];
   assign acc_next   = sat_add64(dot_acc_ff, prod_ff);
   assign is_dot     = (pass_ff == PASS_DOT_SW) || (pass_ff == PASS_DOT_SY) ||
                       (pass_ff == PASS_DOT_YY) || (pass_ff == PASS_DOT_YW);

   always_comb begin
      unique case (pass_ff)
         PASS_UPD_SUB: wb_sum = 49'(work_rd_ff) - 49'(prod_shift);
         PASS_SCALE:   wb_sum = 49'(prod_shift);
         PASS_UPD_ADD: wb_sum = 49'(work_rd_ff) + 49'(prod_shift);
         PASS_NEG:     wb_sum = 49'sd0 - 49'(work_rd_ff);
         default:      wb_sum = 49'(work_rd_ff);
      endcase
   end

   assign wb_value = sat32(wb_sum);
   assign post_v   = sat32(49'(prod_shift));
   assign coef     = sat32(49'(alpha_ff[k_slot]) - 49'(post_v));
   assign ys_gt    = !ys[47] && (ys[46:0] > 47'(thr_ff));
   assign yy_gt    = !yy_ff[47] && (yy_ff[46:0] > 47'(thr_ff));
   assign sy_mag   = sy_ff[47] ? 48'(-sy_ff) : 48'(sy_ff);

   assign div_trial = {div_rem_ff, div_dvd_ff[63]};
   assign div_ge    = div_trial >= {1'b0, div_dvs_ff};

   assign recip_sat  = (|div_quo_ff[63:31]) ? 32'sh7FFF_FFFF : {1'b0, div_quo_ff[30:0]};
   assign gamma_over = (|div_quo_ff[63:32]) || (div_quo_ff[31] && (|div_quo_ff[30:0]));
   assign gamma_sat  = !div_neg_ff ? recip_sat
                     : (gamma_over ? 32'sh8000_0000 : 32'sd0 - div_quo_ff[31:0]);

   // memory ports
   logic               hist_we;
   logic               grad_we;
   logic               wb_work_we;
   logic               dir_we;
   logic               pass_re;
   logic               read_re;
   logic [IDX_W-1:0]   work_waddr;
   logic signed [31:0] work_wdata;

   assign hist_we    = req_fire && (req_payload.kind == KIND_HISTORY) && req_in_range;
   assign grad_we    = req_fire && (req_payload.kind == KIND_GRADIENT) && req_in_range;
   assign read_re    = req_fire && (req_payload.kind == KIND_READ);
   assign pass_re    = state_ff == ST_PASS_RD;
   assign wb_work_we = (state_ff == ST_PASS_WB) && ((pass_ff == PASS_UPD_SUB) ||
                       (pass_ff == PASS_SCALE) || (pass_ff == PASS_UPD_ADD));
   assign dir_we     = (state_ff == ST_PASS_WB) && (pass_ff == PASS_NEG);
   assign work_waddr = grad_we ? req_elem : elem_ff;
   assign work_wdata = grad_we ? req_payload.first_value : wb_value;

   always_ff @(posedge clock) begin
      if (hist_we) step_mem[{head_ff, req_elem}] <= req_payload.first_value;
      if (pass_re) step_rd_ff <= step_mem[{slot_ff, elem_ff}];
   end

   always_ff @(posedge clock) begin
      if (hist_we) chg_mem[{head_ff, req_elem}] <= req_payload.second_value;
      if (pass_re) chg_rd_ff <= chg_mem[{slot_ff, elem_ff}];
   end

   always_ff @(posedge clock) begin
      if (grad_we || wb_work_we) work_mem[work_waddr] <= work_wdata;
      if (pass_re) work_rd_ff <= work_mem[elem_ff];
   end

   always_ff @(posedge clock) begin
      if (dir_we) dir_mem[elem_ff] <= wb_value;
      if (read_re) dir_rd_ff <= dir_mem[req_elem];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_DOT_SW;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THRESH_RESET;
         length_ff    <= LENGTH_RESET;
         depth_ff     <= DEPTH_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         dir_fill_ff  <= '0;
         pair_acc_ff  <= '0;
         pair_pend_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (pair_pend_ff) begin
            pair_acc_ff <= pair_first_ff ? pair_prod_ff : sat_add64(pair_acc_ff, pair_prod_ff);
         end
         pair_pend_ff <= hist_we;

         if (csr_write_en) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff <= csr_data[THRESH_W-1:0];
               CSR_LENGTH: begin
                  length_ff <= csr_data[LENGTH_W-1:0];
                  head_ff   <= '0;
                  count_ff  <= '0;
               end
               CSR_DEPTH: begin
                  depth_ff <= csr_data[DEPTH_W-1:0];
                  head_ff  <= '0;
                  count_ff <= '0;
               end
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_payload.kind)
                     KIND_HISTORY: begin
                        if (req_in_range) begin
                           pair_prod_ff  <= req_payload.first_value * req_payload.second_value;
                           pair_first_ff <= req_payload.index == '0;
                           if (req_last) state_ff <= ST_HFIN;
                        end
                     end
                     KIND_GRADIENT: begin
                        if (req_in_range && req_last) begin
                           k_ff       <= '0;
                           slot_ff    <= newest_slot;
                           elem_ff    <= '0;
                           dot_acc_ff <= '0;
                           state_ff   <= ST_PASS_RD;
                           if (count_ff != '0) begin
                              pass_ff <= PASS_DOT_SW;
                           end else begin
                              pass_ff <= PASS_SCALE;
                              scal_ff <= ONE_Q16;
                           end
                        end
                     end
                     KIND_READ: begin
                        read_hit_ff <= req_in_range && (req_idx_x < CMP_W'(dir_fill_ff));
                        state_ff    <= ST_READ;
                     end
                     default: ;
                  endcase
               end
            end
            ST_READ: begin
               rsp_valid_ff               <= 1'b1;
               rsp_ff.status              <= STATUS_READ;
               rsp_ff.direction_value     <= read_hit_ff ? dir_rd_ff : 32'sd0;
               rsp_ff.history_count       <= 4'(count_ff);
               state_ff                   <= ST_IDLE;
            end
            ST_HFIN: state_ff <= ST_HCHK;
            ST_HCHK: begin
               pair_acc_ff <= '0;
               if (ys_gt) begin
                  div_rem_ff   <= '0;
                  div_dvd_ff   <= 64'h1_0000_0000;
                  div_dvs_ff   <= 48'(ys);
                  div_quo_ff   <= '0;
                  div_cnt_ff   <= '0;
                  div_gamma_ff <= 1'b0;
                  div_neg_ff   <= 1'b0;
                  state_ff     <= ST_DIV;
               end else begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.status          <= STATUS_REJECTED;
                  rsp_ff.direction_value <= 32'sd0;
                  rsp_ff.history_count   <= 4'(count_ff);
                  state_ff               <= ST_IDLE;
               end
            end
            ST_DIV: begin
               div_rem_ff <= div_ge ? 48'(div_trial - {1'b0, div_dvs_ff}) : div_trial[47:0];
               div_dvd_ff <= {div_dvd_ff[62:0], 1'b0};
               div_quo_ff <= {div_quo_ff[62:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'd63) state_ff <= ST_DIVDONE;
            end
            ST_DIVDONE: begin
               if (!div_gamma_ff) begin
                  inv_curv_ff[head_ff]   <= recip_sat;
                  head_ff                <= head_next;
                  count_ff               <= count_next;
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.status          <= STATUS_ACCEPTED;
                  rsp_ff.direction_value <= 32'sd0;
                  rsp_ff.history_count   <= 4'(count_next);
                  state_ff               <= ST_IDLE;
               end else begin
                  scal_ff  <= gamma_sat;
                  pass_ff  <= PASS_SCALE;
                  elem_ff  <= '0;
                  state_ff <= ST_PASS_RD;
               end
            end
            ST_PASS_RD: state_ff <= ST_PASS_MUL;
            ST_PASS_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= ST_PASS_WB;
            end
            ST_PASS_WB: begin
               if (is_dot && !(elem_last && pass_ff == PASS_DOT_SY)) dot_acc_ff <= acc_next;
               if (!elem_last) begin
                  elem_ff  <= elem_ff + IDX_W'(1);
                  state_ff <= ST_PASS_RD;
               end else begin
                  elem_ff  <= '0;
                  unique case (pass_ff)
                     PASS_DOT_SW, PASS_DOT_YW: state_ff <= ST_POST_T;
                     PASS_UPD_SUB: begin
                        dot_acc_ff <= '0;
                        state_ff   <= ST_PASS_RD;
                        if ((k_ff + CNT_W'(1)) < count_ff) begin
                           k_ff    <= k_ff + CNT_W'(1);
                           slot_ff <= (slot_ff == '0) ? last_slot : slot_ff - SLOT_W'(1);
                           pass_ff <= PASS_DOT_SW;
                        end else begin
                           slot_ff <= newest_slot;
                           pass_ff <= PASS_DOT_SY;
                        end
                     end
                     PASS_DOT_SY: begin
                        sy_ff      <= acc_next[63:16];
                        dot_acc_ff <= '0;
                        pass_ff    <= PASS_DOT_YY;
                        state_ff   <= ST_PASS_RD;
                     end
                     PASS_DOT_YY: begin
                        yy_ff    <= acc_next[63:16];
                        state_ff <= ST_GAMMA;
                     end
                     PASS_SCALE: begin
                        dot_acc_ff <= '0;
                        state_ff   <= ST_PASS_RD;
                        if (count_ff != '0) begin
                           k_ff    <= count_ff - CNT_W'(1);
                           slot_ff <= oldest_slot;
                           pass_ff <= PASS_DOT_YW;
                        end else begin
                           pass_ff <= PASS_NEG;
                        end
                     end
                     PASS_UPD_ADD: begin
                        dot_acc_ff <= '0;
                        state_ff   <= ST_PASS_RD;
                        if (k_ff == '0) begin
                           pass_ff <= PASS_NEG;
                        end else begin
                           k_ff    <= k_ff - CNT_W'(1);
                           slot_ff <= (slot_ff == last_slot) ? '0 : slot_ff + SLOT_W'(1);
                           pass_ff <= PASS_DOT_YW;
                        end
                     end
                     default: begin
                        if (LEN_W'(len_eff) > dir_fill_ff) dir_fill_ff <= LEN_W'(len_eff);
                        rsp_valid_ff           <= 1'b1;
                        rsp_ff.status          <= STATUS_READY;
                        rsp_ff.direction_value <= 32'sd0;
                        rsp_ff.history_count   <= 4'(count_ff);
                        state_ff               <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_POST_T: begin
               dot_t_ff <= sat32(49'(acc_shift));
               state_ff <= ST_POST_M;
            end
            ST_POST_M: begin
               prod_ff  <= mul_p;
               state_ff <= ST_POST_A;
            end
            ST_POST_A: begin
               elem_ff  <= '0;
               state_ff <= ST_PASS_RD;
               if (pass_ff == PASS_DOT_SW) begin
                  alpha_ff[k_slot] <= post_v;
                  scal_ff          <= post_v;
                  pass_ff          <= PASS_UPD_SUB;
               end else begin
                  scal_ff <= coef;
                  pass_ff <= PASS_UPD_ADD;
               end
            end
            ST_GAMMA: begin
               if (yy_gt) begin
                  div_rem_ff   <= '0;
                  div_dvd_ff   <= {sy_mag, 16'd0};
                  div_dvs_ff   <= 48'(yy_ff);
                  div_quo_ff   <= '0;
                  div_cnt_ff   <= '0;
                  div_gamma_ff <= 1'b1;
                  div_neg_ff   <= sy_ff[47];
                  state_ff     <= ST_DIV;
               end else begin
                  scal_ff  <= ONE_Q16;
                  pass_ff  <= PASS_SCALE;
                  elem_ff  <= '0;
                  state_ff <= ST_PASS_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= depth_eff)
      else $error("ring count exceeds depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(head_ff) < depth_eff)
      else $error("ring head outside depth");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_rem_ff < div_dvs_ff))
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ tb/sv/tb_lbfgs_direction_engine_unit.sv @@
// Self-checking testbench for lbfgs_direction_engine_unit: directed and random requests,
// a bit-accurate two-loop recursion predictor, random request idling and result back-pressure.
// Depends on lbfgs_de_pkg and lbfgs_direction_engine_unit.
`default_nettype none

module tb_lbfgs_direction_engine_unit;
   import lbfgs_de_pkg::*;

   localparam int NMAX      = 1024;
   localparam int HMAX      = 8;
   localparam int SETTLE    = 100;
   localparam int STALL_MAX = 200000;
   localparam int INT_MAX   = 32'sh7fff_ffff;
   localparam int INT_MIN   = 32'sh8000_0000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   lbfgs_direction_engine_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state
   int      step_mem [HMAX][NMAX];
   int      change_mem [HMAX][NMAX];
   int      inv_curv [HMAX];
   int      alpha_mem [HMAX];
   int      work_vec [NMAX];
   int      dir_vec [NMAX];
   longint  curv_sum;
   int      head;
   int      pairs;
   int      thr_reg;
   int      len_reg;
   int      depth_reg;

   rsp_type pending_results[$];
   int      errors;
   int      requests_sent;
   int      results_seen;
   int      accepted_pairs;
   int      directions_made;
   int      config_writes;
   bit      steady;
   bit      hold_start;
   int      hold_left;
   int      quiet_cycles;

   function automatic int sat32(input longint v);
      if (v > longint'(INT_MAX)) return INT_MAX;
      if (v < longint'(INT_MIN)) return INT_MIN;
      return int'(v);
   endfunction

   function automatic longint sat_add(input longint a, input longint b);
      logic signed [64:0] t;
      t = {a[63], a} + {b[63], b};
      if (t > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
      if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return t[63:0];
   endfunction

   function automatic int mul_q(input int a, input int b);
      return sat32((longint'(a) * longint'(b)) >>> 16);
   endfunction

   function automatic int eff_len();
      if (len_reg == 0) return 1;
      if (len_reg > NMAX) return NMAX;
      return len_reg;
   endfunction

   function automatic int eff_depth();
      if (depth_reg == 0) return 1;
      if (depth_reg > HMAX) return HMAX;
      return depth_reg;
   endfunction

   function automatic int slot_at(input int age, input int d);
      return (head + d + d - 1 - age) % d;
   endfunction

   function automatic longint dot_slot_work(input int slot, input bit use_y, input int n);
      longint acc;
      acc = 0;
      for (int i = 0; i < n; i++)
         acc = sat_add(acc, longint'(use_y ? change_mem[slot][i] : step_mem[slot][i]) *
                            longint'(work_vec[i]));
      return acc >>> 16;
   endfunction

   task automatic run_two_loop(input int n, input int d);
      int           slot;
      int           a;
      int           gamma;
      int           beta;
      int           coef;
      longint       sy;
      longint       yy;
      longint unsigned mag;
      longint unsigned q;
      gamma = ONE_Q16;
      for (int k = 0; k < pairs; k++) begin
         slot = slot_at(k, d);
         a = mul_q(inv_curv[slot], sat32(dot_slot_work(slot, 1'b0, n)));
         alpha_mem[k] = a;
         for (int i = 0; i < n; i++)
            work_vec[i] = sat32(longint'(work_vec[i]) -
                                ((longint'(a) * longint'(change_mem[slot][i])) >>> 16));
      end
      if (pairs > 0) begin
         slot = slot_at(0, d);
         sy = 0;
         yy = 0;
         for (int i = 0; i < n; i++) begin
            sy = sat_add(sy, longint'(step_mem[slot][i]) * longint'(change_mem[slot][i]));
            yy = sat_add(yy, longint'(change_mem[slot][i]) * longint'(change_mem[slot][i]));
         end
         sy = sy >>> 16;
         yy = yy >>> 16;
         if (yy > longint'(thr_reg)) begin
            mag = (sy < 0) ? -sy : sy;
            q = (mag << 16) / unsigned'(yy);
            if (sy >= 0)
               gamma = (q > 64'd2147483647) ? INT_MAX : int'(q);
            else
               gamma = (q > 64'd2147483648) ? INT_MIN : sat32(-longint'(q));
         end
      end
      for (int i = 0; i < n; i++)
         work_vec[i] = mul_q(gamma, work_vec[i]);
      for (int k = pairs; k > 0; k--) begin
         slot = slot_at(k - 1, d);
         beta = mul_q(inv_curv[slot], sat32(dot_slot_work(slot, 1'b1, n)));
         coef = sat32(longint'(alpha_mem[k - 1]) - longint'(beta));
         for (int i = 0; i < n; i++)
            work_vec[i] = sat32(longint'(work_vec[i]) +
                                ((longint'(step_mem[slot][i]) * longint'(coef)) >>> 16));
      end
      for (int i = 0; i < n; i++)
         dir_vec[i] = sat32(-longint'(work_vec[i]));
   endtask

   task automatic predict_request(input req_type r);
      int      n;
      int      d;
      int      idx;
      longint  ys;
      longint unsigned q;
      rsp_type e;
      n = eff_len();
      d = eff_depth();
      idx = r.index;
      e.direction_value = '0;
      case (r.kind)
         KIND_HISTORY: begin
            if (idx >= n) return;
            step_mem[head][idx] = r.first_value;
            change_mem[head][idx] = r.second_value;
            curv_sum = (idx == 0) ? longint'(r.first_value) * longint'(r.second_value) :
                       sat_add(curv_sum, longint'(r.first_value) * longint'(r.second_value));
            if (idx != n - 1) return;
            ys = curv_sum >>> 16;
            curv_sum = 0;
            if (ys > longint'(thr_reg)) begin
               q = 64'h1_0000_0000 / longint'(unsigned'(ys));
               inv_curv[head] = (q > 64'd2147483647) ? INT_MAX : int'(q);
               head = (head + 1) % d;
               if (pairs < d) pairs++;
               e.status = STATUS_ACCEPTED;
               accepted_pairs++;
            end else begin
               e.status = STATUS_REJECTED;
            end
         end
         KIND_GRADIENT: begin
            if (idx >= n) return;
            work_vec[idx] = r.first_value;
            if (idx != n - 1) return;
            run_two_loop(n, d);
            e.status = STATUS_READY;
            directions_made++;
         end
         KIND_READ: begin
            e.status = STATUS_READ;
            if (idx < n) e.direction_value = dir_vec[idx];
         end
         default: return;
      endcase
      e.history_count = pairs[3:0];
      pending_results.push_back(e);
   endtask

   task automatic send_request(input logic [1:0] kind, input int idx, input int fv,
                               input int sv);
      req_type r;
      if (!steady && $urandom_range(99) < 11) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      r.kind = kind;
      r.index = idx[9:0];
      r.first_value = fv;
      r.second_value = sv;
      req_payload = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int value);
      drain();
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_data = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_en = 1'b0;
      config_writes++;
      case (idx)
         CSR_THRESHOLD: thr_reg = value & 32'h7fff_ffff;
         CSR_LENGTH: begin
            len_reg = value & 32'h7ff;
            head = 0;
            pairs = 0;
         end
         CSR_DEPTH: begin
            depth_reg = value & 32'hf;
            head = 0;
            pairs = 0;
         end
         default: ;
      endcase
   endtask

   task automatic configure(input int thr, input int len, input int dep);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_LENGTH, len);
      write_csr(CSR_DEPTH, dep);
   endtask

   function automatic int rand_q(input int mode);
      case (mode)
         0: return $urandom();
         1: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         default: case ($urandom_range(3))
            0: return INT_MAX;
            1: return INT_MIN;
            2: return 0;
            default: return -1;
         endcase
      endcase
   endfunction

   function automatic int pick_mode();
      int x;
      x = $urandom_range(99);
      if (x < 20) return 0;
      if (x < 90) return 1;
      return 2;
   endfunction

   // stop_at < n leaves the load open without ending it
   task automatic load_pair(input int mode, input bit curved, input int stop_at);
      int s;
      int y;
      for (int i = 0; i < eff_len() && i < stop_at; i++) begin
         s = rand_q(mode);
         y = curved ? sat32(longint'(s) + longint'(rand_q(1) >>> 4)) : rand_q(mode);
         send_request(KIND_HISTORY, i, s, y);
      end
   endtask

   task automatic load_gradient(input int mode, input int stop_at);
      for (int i = 0; i < eff_len() && i < stop_at; i++)
         send_request(KIND_GRADIENT, i, rand_q(mode), rand_q(0));
   endtask

   task automatic read_direction(input int count);
      for (int i = 0; i < count; i++)
         send_request(KIND_READ, (i < eff_len()) ? i : $urandom_range(NMAX - 1),
                      rand_q(0), rand_q(0));
   endtask

   task automatic test_reset_state();
      read_direction(3);
      send_request(KIND_READ, NMAX - 1, 0, 0);
      send_request(KIND_UNUSED, 0, rand_q(0), rand_q(0));
      drain();
   endtask

   task automatic test_extremes();
      configure(0, 3, 2);
      send_request(KIND_HISTORY, 0, INT_MIN, INT_MIN);
      send_request(KIND_HISTORY, 1, INT_MIN, INT_MIN);
      send_request(KIND_HISTORY, 2, INT_MAX, INT_MAX);
      send_request(KIND_HISTORY, 0, INT_MAX, INT_MIN);
      send_request(KIND_HISTORY, 1, 0, -1);
      send_request(KIND_HISTORY, 2, 1, 1);
      send_request(KIND_HISTORY, 5, 1, 1);
      send_request(KIND_HISTORY, 0, 32'sh0001_0000, 32'sh0002_0000);
      send_request(KIND_HISTORY, 1, -32'sh0000_8000, -32'sh0001_0000);
      send_request(KIND_HISTORY, 2, 32'sh0000_4000, 32'sh0000_0100);
      send_request(KIND_GRADIENT, 0, INT_MIN, 0);
      send_request(KIND_GRADIENT, 1, INT_MAX, 0);
      send_request(KIND_GRADIENT, 7, 1, 0);
      send_request(KIND_GRADIENT, 2, 32'sh0003_0000, 0);
      read_direction(3);
      send_request(KIND_READ, 3, 0, 0);
      drain();
   endtask

   task automatic test_size_limits();
      configure(32'h7fff_ffff, 0, 0);
      load_pair(1, 1'b1, NMAX);
      load_gradient(2, NMAX);
      read_direction(2);
      configure(0, 1, 15);
      load_pair(1, 1'b1, NMAX);
      load_gradient(2, NMAX);
      read_direction(1);
      configure(1, 2047, 1);
      load_gradient(1, NMAX);
      send_request(KIND_READ, 0, 0, 0);
      send_request(KIND_READ, NMAX - 1, 0, 0);
      drain();
   endtask

   task automatic test_ring_wrap();
      configure(0, 2, 8);
      for (int p = 0; p < 11; p++) load_pair(1, 1'b1, NMAX);
      load_pair(2, 1'b0, NMAX);
      load_gradient(1, NMAX);
      read_direction(2);
      drain();
   endtask

   task automatic test_back_pressure();
      configure(0, 4, 3);
      load_pair(1, 1'b1, NMAX);
      load_gradient(1, NMAX);
      drain();
      hold_start = 1'b1;
      steady = 1'b1;
      read_direction(60);
      steady = 1'b0;
      drain();
   endtask

   task automatic test_random_traffic();
      int op;
      int n;
      int phase_end;
      while (requests_sent < 1300) begin
         case ($urandom_range(3))
            0: configure(0, $urandom_range(1, 16), $urandom_range(1, 8));
            1: configure($urandom_range(0, 32'h0004_0000), $urandom_range(1, 12),
                         $urandom_range(1, 8));
            2: configure($urandom(), $urandom_range(1, 8), $urandom_range(1, 8));
            default: configure($urandom_range(0, 16), $urandom_range(1, 24),
                               $urandom_range(1, 8));
         endcase
         steady = ($urandom_range(3) == 0);
         n = eff_len();
         phase_end = requests_sent + 50;
         while (requests_sent < phase_end) begin
            op = $urandom_range(99);
            if (op < 35)
               load_pair(pick_mode(), $urandom_range(9) < 7, NMAX);
            else if (op < 55)
               load_gradient(pick_mode(), NMAX);
            else if (op < 80)
               read_direction($urandom_range(1, 8));
            else if (op < 90) begin
               if (n > 1) begin
                  if ($urandom_range(1)) load_pair(pick_mode(), 1'b1, $urandom_range(1, n - 1));
                  else load_gradient(pick_mode(), $urandom_range(1, n - 1));
               end
            end else if ($urandom_range(1) || n == NMAX)
               send_request(KIND_UNUSED, $urandom_range(NMAX - 1), rand_q(0), rand_q(0));
            else
               send_request($urandom_range(1), $urandom_range(n, NMAX - 1),
                            rand_q(0), rand_q(0));
         end
         steady = 1'b0;
      end
      drain();
   endtask

   // result channel: random stalls plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else
            rsp_ready = steady || ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result status=%0d", rsp_payload.status);
            errors++;
         end else begin
            rsp_type e;
            e = pending_results.pop_front();
            if (rsp_payload.status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_payload.status);
               errors++;
            end
            if (rsp_payload.direction_value !== e.direction_value) begin
               $error("direction_value: expected %0d actual %0d",
                      e.direction_value, rsp_payload.direction_value);
               errors++;
            end
            if (rsp_payload.history_count !== e.history_count) begin
               $error("history_count: expected %0d actual %0d",
                      e.history_count, rsp_payload.history_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_MAX) begin
         $display("CHECK FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      steady = 1'b0;
      hold_start = 1'b0;
      quiet_cycles = 0;
      errors = 0;
      requests_sent = 0;
      results_seen = 0;
      accepted_pairs = 0;
      directions_made = 0;
      config_writes = 0;
      curv_sum = 0;
      head = 0;
      pairs = 0;
      thr_reg = THRESH_RESET;
      len_reg = LENGTH_RESET;
      depth_reg = DEPTH_RESET;
      for (int i = 0; i < NMAX; i++) begin
         dir_vec[i] = 0;
         work_vec[i] = 0;
      end
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_state();
      test_extremes();
      test_size_limits();
      test_ring_wrap();
      test_back_pressure();
      test_random_traffic();

      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         errors++;
      end
      $display("covered %0d requests, %0d results, %0d register writes",
               requests_sent, results_seen, config_writes);
      $display("pairs kept %0d, directions computed %0d", accepted_pairs, directions_made);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
